@@ rtl/bhu_pkg.sv @@
// Shared types and codes for the breakpoint halt unit.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package bhu_pkg;

	localparam int ADDR_W = 64;

	// Command codes
	localparam logic [2:0] CMD_CHECK   = 3'd0;
	localparam logic [2:0] CMD_INSERT  = 3'd1;
	localparam logic [2:0] CMD_REMOVE  = 3'd2;
	localparam logic [2:0] CMD_HALT    = 3'd3;
	localparam logic [2:0] CMD_QHALT   = 3'd4;
	localparam logic [2:0] CMD_RESUME  = 3'd5;
	localparam logic [2:0] CMD_CONNECT = 3'd6;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	// Request token that walks the cell chain.
	// hit: check matched, insert placed, or remove cleared an entry.
	typedef struct packed {
		logic              vld;
		logic [2:0]        cmd;
		logic [ADDR_W-1:0] addr;
		logic              hit;
	} token_t;

endpackage

@@ rtl/breakpoint_halt_unit_top.sv @@
// Top level of the breakpoint halt unit: sequencer plus a row of entry cells.
// Depends on bhu_pkg, bhu_cell and bhu_ctrl.
//
// Usage: drive cmd and address with start high while busy is low; the
// request is taken at that clock edge. It then walks a chain of BP_ENTRIES
// cells, one cell per clock, each cell holding one breakpoint entry and
// comparing its address against the request. Exactly one result comes back
// per request: done is high for a single cycle with halted, send_trap,
// status and invalidate valid in that cycle only. The receiver cannot stall
// the unit, so capture the result whenever done is high. A request passes
// through one launch stage, one stage per cell and one result stage on its
// way from acceptance to done; busy is low again in the done cycle, so the
// next request may be taken then. The chain length sets how long that takes.
// Commands: check pc, insert, remove, halt, quiet halt, resume, connect.
// Insert takes the lowest free entry, remove clears the lowest matching one;
// connect clears every entry and halts.
module breakpoint_halt_unit_top #(
	parameter int BP_ENTRIES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 cmd,
	input  logic [bhu_pkg::ADDR_W-1:0] address,
	output logic                       done,
	output logic                       halted,
	output logic                       send_trap,
	output logic [1:0]                 status,
	output logic                       invalidate
);

	// chain[i] feeds cell i; chain[BP_ENTRIES] returns to the sequencer
	bhu_pkg::token_t chain [BP_ENTRIES+1];

	bhu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.address    (address),
		.busy       (busy),
		.tok_launch (chain[0]),
		.tok_return (chain[BP_ENTRIES]),
		.done       (done),
		.halted     (halted),
		.send_trap  (send_trap),
		.status     (status),
		.invalidate (invalidate)
	);

	// Advance the request one entry per clock; lower index wins on insert/remove
	for (genvar gi = 0; gi < BP_ENTRIES; gi++) begin : g_cell
		bhu_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tin    (chain[gi]),
			.tout   (chain[gi+1])
		);
	end

endmodule

@@ rtl/bhu_cell.sv @@
// One breakpoint entry of the cell chain: address, valid bit, token stage.
// Depends on bhu_pkg.
module bhu_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  bhu_pkg::token_t tin,
	output bhu_pkg::token_t tout
);

	logic                       valid_q;
	logic [bhu_pkg::ADDR_W-1:0] addr_q;
	logic                       match;
	logic                       vld_s1;
	bhu_pkg::token_t            tok_s1;
	bhu_pkg::token_t            tnext;

	assign match = valid_q && (addr_q == tin.addr);

	always_comb begin
		tnext = tin;
		case (tin.cmd)
			bhu_pkg::CMD_CHECK: begin
				tnext.hit = tin.hit | match;
			end
			bhu_pkg::CMD_INSERT: begin
				if (!tin.hit && !valid_q) tnext.hit = 1'b1;
			end
			bhu_pkg::CMD_REMOVE: begin
				if (!tin.hit && match) tnext.hit = 1'b1;
			end
			default: begin
				tnext.hit = tin.hit;
			end
		endcase
	end

	// Entry update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (tin.vld) begin
			case (tin.cmd)
				bhu_pkg::CMD_INSERT: begin
					if (!tin.hit && !valid_q) valid_q <= 1'b1;
				end
				bhu_pkg::CMD_REMOVE: begin
					if (!tin.hit && match) valid_q <= 1'b0;
				end
				bhu_pkg::CMD_CONNECT: begin
					valid_q <= 1'b0;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tin.vld && tin.cmd == bhu_pkg::CMD_INSERT && !tin.hit && !valid_q) begin
			addr_q <= tin.addr;
		end
	end

	// Token stage toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= tin.vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_s1 <= tnext;
	end

	always_comb begin
		tout     = tok_s1;
		tout.vld = vld_s1;
	end

endmodule

@@ rtl/bhu_ctrl.sv @@
// Request sequencer and halt state: launches a token into the chain,
// resolves it at the chain end. Depends on bhu_pkg.
module bhu_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [2:0]                 cmd,
	input  logic [bhu_pkg::ADDR_W-1:0] address,
	output logic                       busy,
	output bhu_pkg::token_t            tok_launch,
	input  bhu_pkg::token_t            tok_return,
	output logic                       done,
	output logic                       halted,
	output logic                       send_trap,
	output logic [1:0]                 status,
	output logic                       invalidate
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

	state_t          state_q;
	logic            accept;
	logic            force_halt_q;
	logic            trap_sent_q;
	logic            fh_n;
	logic            ts_n;
	logic            trap_n;
	logic [1:0]      status_n;
	logic            inval_n;
	logic            launch_vld_q;
	bhu_pkg::token_t launch_q;
	logic            done_q;
	logic            halted_q;
	logic            trap_q;
	logic [1:0]      status_q;
	logic            inval_q;

	assign busy   = (state_q == S_WALK);
	assign accept = start && !busy;

	always_comb begin
		fh_n     = force_halt_q;
		ts_n     = trap_sent_q;
		trap_n   = 1'b0;
		status_n = bhu_pkg::ST_OK;
		inval_n  = 1'b0;
		case (tok_return.cmd)
			bhu_pkg::CMD_CHECK: begin
				if (force_halt_q || tok_return.hit) begin
					fh_n = 1'b1;
					if (!trap_sent_q) begin
						ts_n   = 1'b1;
						trap_n = 1'b1;
					end
				end
			end
			bhu_pkg::CMD_INSERT: begin
				inval_n = 1'b1;
				if (!tok_return.hit) status_n = bhu_pkg::ST_FULL;
			end
			bhu_pkg::CMD_REMOVE: begin
				inval_n = 1'b1;
				if (!tok_return.hit) status_n = bhu_pkg::ST_NOMATCH;
			end
			bhu_pkg::CMD_HALT: begin
				fh_n = 1'b1;
				ts_n = 1'b0;
			end
			bhu_pkg::CMD_QHALT: begin
				fh_n = 1'b1;
				ts_n = 1'b1;
			end
			bhu_pkg::CMD_RESUME: begin
				fh_n = 1'b0;
				ts_n = 1'b0;
			end
			bhu_pkg::CMD_CONNECT: begin
				fh_n = 1'b1;
				ts_n = 1'b0;
			end
			default: begin
				fh_n = force_halt_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			launch_vld_q <= 1'b0;
			done_q       <= 1'b0;
			force_halt_q <= 1'b0;
			trap_sent_q  <= 1'b0;
		end else begin
			launch_vld_q <= accept;
			done_q       <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_WALK;
				end
				S_WALK: begin
					if (tok_return.vld) begin
						state_q      <= S_IDLE;
						done_q       <= 1'b1;
						force_halt_q <= fh_n;
						trap_sent_q  <= ts_n;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			launch_q.cmd  <= cmd;
			launch_q.addr <= address;
			launch_q.hit  <= 1'b0;
			launch_q.vld  <= 1'b1;
		end
		if (tok_return.vld) begin
			halted_q <= fh_n;
			trap_q   <= trap_n;
			status_q <= status_n;
			inval_q  <= inval_n;
		end
	end

	always_comb begin
		tok_launch     = launch_q;
		tok_launch.vld = launch_vld_q;
	end

	assign done       = done_q;
	assign halted     = halted_q;
	assign send_trap  = trap_q;
	assign status     = status_q;
	assign invalidate = inval_q;

endmodule
